// ----- hdl/hsh_pkg.sv -----
// shared types, constants and hash step for the sampled hit check block
package hsh_pkg;

    localparam int unsigned DIGEST_W   = 64;
    localparam int unsigned RATE_W     = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned DIV_CNT_W  = $clog2(DIGEST_W);

    localparam logic [DIGEST_W-1:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
    // prime 0x100000001b3 = 2^40 + 2^8 + 0xb3
    localparam int unsigned         FNV_SHIFT_HI = 40;
    localparam int unsigned         FNV_SHIFT_LO = 8;
    localparam logic [7:0]          FNV_PRIME_LOW = 8'hB3;

    // closed key handed from the hash front to the queue
    typedef struct packed {
        logic                valid;
        logic [DIGEST_W-1:0] digest;
    } key_push_t;

    // queue status seen by the input handshake and the back
    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_OUTPUT
    } back_state_t;

    // one fnv-1a step: xor the byte in, multiply by the prime mod 2^64
    function automatic logic [DIGEST_W-1:0] fnv_step(
        input logic [DIGEST_W-1:0] hash_in,
        input logic [BYTE_W-1:0]   byte_in
    );
        logic [DIGEST_W-1:0] h_x;
        logic [DIGEST_W-1:0] mul_low;
        h_x     = hash_in ^ {{(DIGEST_W-BYTE_W){1'b0}}, byte_in};
        mul_low = h_x * {{(DIGEST_W-8){1'b0}}, FNV_PRIME_LOW};
        return (h_x << FNV_SHIFT_HI) + (h_x << FNV_SHIFT_LO) + mul_low;
    endfunction

endpackage

// ----- hdl/hsh_front.sv -----
// hash front: takes key bytes and pushes each closed key's digest
module hsh_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [hsh_pkg::BYTE_W-1:0]  key_byte,
    input  logic                        is_last,
    input  logic                        is_empty,
    output hsh_pkg::key_push_t          push
);
    import hsh_pkg::*;

    logic [DIGEST_W-1:0] hash_reg;
    logic [DIGEST_W-1:0] hash_next;
    logic [DIGEST_W-1:0] stepped;

    // running hash update and key close
    always_comb
    begin
        stepped     = fnv_step(hash_reg, key_byte);
        hash_next   = hash_reg;
        push.valid  = 1'b0;
        push.digest = stepped;
        if (accept)
        begin
            if (is_empty)
            begin
                push.valid  = 1'b1;
                push.digest = hash_reg;
                hash_next   = FNV_OFFSET_BASIS;
            end
            else if (is_last)
            begin
                push.valid = 1'b1;
                hash_next  = FNV_OFFSET_BASIS;
            end
            else
            begin
                hash_next = stepped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_reg <= FNV_OFFSET_BASIS;
        else
            hash_reg <= hash_next;
    end

endmodule

// ----- hdl/hsh_queue.sv -----
// short fifo of closed-key digests between front and back
module hsh_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hsh_pkg::key_push_t            push,
    input  logic                          pop,
    output logic [hsh_pkg::DIGEST_W-1:0]  head,
    output hsh_pkg::queue_status_t        status
);
    import hsh_pkg::*;

    logic [DIGEST_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    // status and head
    always_comb
    begin
        status.full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
        status.nonempty = (count_reg != '0);
        head            = entry_reg[rd_ptr_reg];
        do_push         = push.valid && !status.full;
        do_pop          = pop && status.nonempty;
    end

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.digest;
    end

endmodule

// ----- hdl/hsh_back.sv -----
// decision back end: bit-serial digest modulo rate and result register
module hsh_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hsh_pkg::RATE_W-1:0]    verify_rate,
    input  hsh_pkg::queue_status_t        status,
    input  logic [hsh_pkg::DIGEST_W-1:0]  head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_verify,
    output logic [hsh_pkg::DIGEST_W-1:0]  out_digest
);
    import hsh_pkg::*;

    back_state_t           state_reg, state_next;
    logic [DIGEST_W-1:0]   digest_reg, digest_next;
    logic [DIGEST_W-1:0]   shift_reg, shift_next;
    logic [RATE_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  verify_reg, verify_next;
    logic [RATE_W:0]       rem_shift;
    logic [RATE_W:0]       rem_sub;
    logic                  rem_ge;
    logic [RATE_W-1:0]     rem_step;
    logic                  rate_trivial;

    // one restoring step of the remainder
    always_comb
    begin
        rem_shift    = {rem_reg, shift_reg[DIGEST_W-1]};
        rem_sub      = rem_shift - {1'b0, verify_rate};
        rem_ge       = (rem_shift >= {1'b0, verify_rate});
        rem_step     = rem_ge ? rem_sub[RATE_W-1:0] : rem_shift[RATE_W-1:0];
        rate_trivial = (verify_rate[RATE_W-1:1] == '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.nonempty)
                    state_next = rate_trivial ? ST_OUTPUT : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                    state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop         = 1'b0;
        out_valid   = 1'b0;
        digest_next = digest_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        verify_next = verify_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.nonempty)
                begin
                    pop         = 1'b1;
                    digest_next = head;
                    shift_next  = head;
                    rem_next    = '0;
                    cnt_next    = DIV_CNT_W'(DIGEST_W - 1);
                    verify_next = verify_rate[0];
                end
            end
            ST_DIVIDE:
            begin
                rem_next   = rem_step;
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    verify_next = (rem_step == '0);
            end
            ST_OUTPUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        out_verify = verify_reg;
        out_digest = digest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        digest_reg <= digest_next;
        shift_reg  <= shift_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        verify_reg <= verify_next;
    end

endmodule

// ----- hdl/hash_sampled_hit_check.sv -----
// top level of the sampled hit check: rate register, hash front, queue, decision back
//
// Key bytes are taken one per cycle and folded into a running 64-bit FNV-1a
// hash; an item with tlast closes the key after its byte, an item with tuser
// set closes it without a byte. Each closed key yields one result beat with
// the digest on m_tdata and the verify decision on m_tuser. Closed digests
// wait in a four-entry queue; input is held off only while that queue is
// full. For a rate of 0 or 1 the decision goes from the queue head straight
// to the output state; any other rate runs a one-bit-per-cycle remainder
// loop over the 64 digest bits, which holds the back end on one key at a
// time and sets the sustained rate of closed keys. The rate register may
// be written only while no key is open or in flight.
module hash_sampled_hit_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // verify_rate
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // key_byte
    input  logic        s_tlast,       // is_last
    input  logic        s_tuser,       // is_empty
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // digest
    output logic        m_tuser        // verify
);
    import hsh_pkg::*;

    logic [RATE_W-1:0]   rate_reg;
    key_push_t           push;
    queue_status_t       status;
    logic [DIGEST_W-1:0] head;
    logic                pop;
    logic                s_accept;

    // rate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= '0;
        else if (cfg_wr_en)
            rate_reg <= cfg_wr_data;
    end

    // input beat handshake
    assign s_tready = !status.full;
    assign s_accept = s_tvalid && s_tready;

    hsh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (s_accept),
        .key_byte (s_tdata),
        .is_last  (s_tlast),
        .is_empty (s_tuser),
        .push     (push)
    );

    hsh_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (status)
    );

    hsh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .verify_rate (rate_reg),
        .status      (status),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_verify  (m_tuser),
        .out_digest  (m_tdata)
    );

endmodule

// ----- tb/sv/tb.sv -----
// testbench for hash_sampled_hit_check: fnv-1a digest and sampled verify decision
`timescale 1ns / 100ps

module tb;

    localparam logic [63:0] HASH_SEED  = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] HASH_PRIME = 64'h0000_0100_0000_01B3;
    localparam int          SETTLE_CYCLES = 80;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // one closed key as it should leave the block
    typedef struct packed {
        logic        verify;
        logic [63:0] digest;
    } hit_verdict_t;

    // running hash, sampling rate and the verdicts still owed by the block
    class hit_check_scoreboard;
        logic [63:0]  fnv_state;
        logic [31:0]  sample_rate;
        hit_verdict_t owed[$];
        int           mismatches;

        function new();
            fnv_state   = HASH_SEED;
            sample_rate = 32'd0;
            mismatches  = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // fold an accepted input beat into the hash, close the key when marked
        function void note_beat(logic [7:0] key_byte, logic is_last, logic is_empty);
            hit_verdict_t v;
            if (!is_empty)
            begin
                fnv_state = (fnv_state ^ {56'd0, key_byte}) * HASH_PRIME;
                if (!is_last)
                    return;
            end
            v.digest = fnv_state;
            if (sample_rate == 32'd0)
                v.verify = 1'b0;
            else if (sample_rate == 32'd1)
                v.verify = 1'b1;
            else
                v.verify = (fnv_state % {32'd0, sample_rate}) == 64'd0;
            owed.insert(owed.size(), v);
            fnv_state = HASH_SEED;
        endfunction

        task flag_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        // compare one accepted result beat with the oldest owed verdict
        task check_result(logic verify, logic [63:0] digest);
            hit_verdict_t want;
            if (owed.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result digest=%h verify=%b",
                                        digest, verify));
                return;
            end
            want = owed.pop_front();
            if (digest !== want.digest)
                flag_mismatch($sformatf("digest got %h want %h", digest, want.digest));
            if (verify !== want.verify)
                flag_mismatch($sformatf("verify got %b want %b (digest %h rate %0d)",
                                        verify, want.verify, want.digest, sample_rate));
        endtask
    endclass

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;   // key_byte
    logic        s_tlast     = 1'b0;   // is_last
    logic        s_tuser     = 1'b0;   // is_empty
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [63:0] m_tdata;              // digest
    logic        m_tuser;              // verify

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;

    hit_check_scoreboard sb = new();

    hash_sampled_hit_check dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: check accepted beats, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND:
            begin
                send_idle_pct  = 66;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 66;
            end
            default:
            begin
                send_idle_pct  = 13;
                recv_stall_pct = 13;
            end
        endcase
    endtask

    // one input beat, with a random gap in front, held until accepted
    task automatic send_beat(input logic [7:0] key_byte, input logic is_last,
                             input logic is_empty);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key_byte;
        s_tlast  <= is_last;
        s_tuser  <= is_empty;
        do @(posedge clk); while (!s_tready);
        sb.note_beat(key_byte, is_last, is_empty);
        beats_sent++;
    endtask

    // hold input off until every owed result is back, then let the block settle
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_rate(input logic [31:0] rate);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rate;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= $urandom;
        sb.sample_rate = rate;
        @(posedge clk);
    endtask

    // one well-formed key with random content, or now and then an odd closing
    task automatic send_random_key();
        int key_len;
        int close_kind;
        key_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
        close_kind = $urandom_range(9);
        if (key_len == 0)
        begin
            // empty key, byte and last mark are don't-care
            send_beat(8'($urandom), 1'($urandom_range(1)), 1'b1);
            return;
        end
        for (int i = 0; i < key_len - 1; i++)
            send_beat(8'($urandom), 1'b0, 1'b0);
        if (close_kind < 2)
        begin
            // all bytes unmarked, closed by an empty item
            send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'($urandom_range(1)), 1'b1);
        end
        else
        begin
            send_beat(8'($urandom), 1'b1, 1'b0);
        end
    endtask

    task automatic run_phase(input logic [31:0] rate, input idle_mode_t mode,
                             input int n_beats);
        int stop_at;
        bit paused;
        drain(SETTLE_CYCLES);
        write_rate(rate);
        set_idling(mode);
        stop_at = beats_sent + n_beats;
        paused  = 1'b0;
        while (beats_sent < stop_at)
        begin
            send_random_key();
            // sender waits out the block once per phase
            if (!paused && beats_sent >= stop_at - n_beats / 2)
            begin
                drain(0);
                paused = 1'b1;
            end
        end
    endtask

    // main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed keys at the reset rate, no idling
        set_idling(IDLE_NONE);
        send_beat(8'h5A, 1'b0, 1'b1);   // empty key right after reset
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h61, 1'b0, 1'b0);   // multi-byte key
        send_beat(8'h62, 1'b0, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'h12, 1'b0, 1'b0);   // pending bytes closed by an empty item
        send_beat(8'h34, 1'b0, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);
        send_beat(8'hA5, 1'b1, 1'b1);   // empty wins over last
        send_beat(8'h00, 1'b0, 1'b1);   // empty after closed key
        send_beat(8'h80, 1'b0, 1'b0);
        send_beat(8'h7F, 1'b0, 1'b0);
        send_beat(8'h01, 1'b1, 1'b0);

        // rate sweep across idling styles
        run_phase(32'd1,                  IDLE_NONE, 150);
        run_phase(32'd2,                  IDLE_SEND, 200);
        run_phase(32'd3,                  IDLE_RECV, 200);
        run_phase(32'hFFFF_FFFF,          IDLE_BOTH, 150);
        run_phase(32'd0,                  IDLE_NONE, 100);
        run_phase($urandom_range(2, 16),  IDLE_BOTH, 200);
        run_phase(32'h8000_0000,          IDLE_RECV, 100);
        run_phase($urandom,               IDLE_SEND, 100);
        run_phase(32'd1,                  IDLE_BOTH, 50);

        drain(SETTLE_CYCLES);
        if (sb.pending() != 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
